// ----- hw/rtl/sm83enc_pkg.sv -----
// ----------------------------------------------------------------------------
// sm83enc_pkg
// Shared types and codes for the SM83 instruction encoder: mnemonic codes,
// operand class codes, error causes and register field selectors.
// ----------------------------------------------------------------------------
package sm83enc_pkg;

  localparam logic [5:0] K_STOP = 6'd10;
  localparam logic [5:0] K_RETI = 6'd13;
  localparam logic [5:0] K_RET  = 6'd14;
  localparam logic [5:0] K_RST  = 6'd15;
  localparam logic [5:0] K_JP   = 6'd16;
  localparam logic [5:0] K_JR   = 6'd17;
  localparam logic [5:0] K_CALL = 6'd18;
  localparam logic [5:0] K_PUSH = 6'd19;
  localparam logic [5:0] K_POP  = 6'd20;
  localparam logic [5:0] K_ADD  = 6'd21;
  localparam logic [5:0] K_CP   = 6'd28;
  localparam logic [5:0] K_INC  = 6'd29;
  localparam logic [5:0] K_DEC  = 6'd30;
  localparam logic [5:0] K_RLC  = 6'd31;
  localparam logic [5:0] K_SRL  = 6'd38;
  localparam logic [5:0] K_BIT  = 6'd39;
  localparam logic [5:0] K_SET  = 6'd41;
  localparam logic [5:0] K_LD   = 6'd42;
  localparam logic [5:0] K_LDH  = 6'd43;

  localparam logic [4:0] CL_C       = 5'd1;
  localparam logic [4:0] CL_L       = 5'd5;
  localparam logic [4:0] CL_A       = 5'd6;
  localparam logic [4:0] CL_BC      = 5'd7;
  localparam logic [4:0] CL_HL      = 5'd9;
  localparam logic [4:0] CL_SP      = 5'd10;
  localparam logic [4:0] CL_AF      = 5'd11;
  localparam logic [4:0] CL_NZ      = 5'd12;
  localparam logic [4:0] CL_NC      = 5'd14;
  localparam logic [4:0] CL_MEM_BC  = 5'd16;
  localparam logic [4:0] CL_MEM_DE  = 5'd17;
  localparam logic [4:0] CL_MEM_HL  = 5'd18;
  localparam logic [4:0] CL_MEM_HLI = 5'd19;
  localparam logic [4:0] CL_MEM_HLD = 5'd20;
  localparam logic [4:0] CL_MEM_C   = 5'd21;
  localparam logic [4:0] CL_MEM_ADR = 5'd22;
  localparam logic [4:0] CL_IMM     = 5'd24;
  localparam logic [4:0] CL_SP_PLUS = 5'd25;
  localparam logic [4:0] CL_SP_MIN  = 5'd26;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_UNKNOWN = 3'd1,
    ERR_COUNT   = 3'd2,
    ERR_OPERAND = 3'd3,
    ERR_RANGE   = 3'd4
  } cause_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } sel2_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] code;
  } sel3_t;

  localparam logic [7:0] PLAIN_OPS [14] = '{
    8'h00, 8'h07, 8'h0F, 8'h17, 8'h1F, 8'h27, 8'h2F,
    8'h37, 8'h3F, 8'h76, 8'h10, 8'hF3, 8'hFB, 8'hD9
  };

  function automatic sel2_t cc_of(logic [4:0] c);
    sel2_t s;
    s.ok   = 1'b1;
    s.code = 2'd3;
    if (c >= CL_NZ && c <= CL_NC) s.code = 2'(c - CL_NZ);
    else if (c != CL_C) s.ok = 1'b0;
    return s;
  endfunction

  function automatic sel2_t rp_of(logic [4:0] c);
    sel2_t s;
    s.ok   = (c >= CL_BC && c <= CL_SP);
    s.code = 2'(c - CL_BC);
    return s;
  endfunction

  function automatic sel2_t rp2_of(logic [4:0] c);
    sel2_t s;
    s.ok   = (c >= CL_BC && c <= CL_HL) || c == CL_AF;
    s.code = (c == CL_AF) ? 2'd3 : 2'(c - CL_BC);
    return s;
  endfunction

  function automatic sel3_t r_of(logic [4:0] c);
    sel3_t s;
    s.ok   = 1'b1;
    s.code = c[2:0];
    if (c == CL_A) s.code = 3'd7;
    else if (c == CL_MEM_HL) s.code = 3'd6;
    else if (c > CL_L) s.ok = 1'b0;
    return s;
  endfunction

endpackage

// ----- hw/rtl/sm83enc_if.sv -----
// ----------------------------------------------------------------------------
// sm83enc_if
// Request and response channels of the SM83 instruction encoder, with
// valid/ready handshake and the item fields.
// ----------------------------------------------------------------------------
interface sm83enc_req_if;
  logic               valid;
  logic               ready;
  logic [5:0]         kind;
  logic [1:0]         operand_count;
  logic [4:0]         first_operand;
  logic [4:0]         second_operand;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic [15:0]        current_address;

  modport source (
    output valid, kind, operand_count, first_operand, second_operand,
           first_value, second_value, current_address,
    input  ready
  );
  modport sink (
    input  valid, kind, operand_count, first_operand, second_operand,
           first_value, second_value, current_address,
    output ready
  );
endinterface

interface sm83enc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] byte_count;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [2:0] error_cause;

  modport source (
    output valid, byte_count, first_byte, second_byte, third_byte, error_cause,
    input  ready
  );
  modport sink (
    input  valid, byte_count, first_byte, second_byte, third_byte, error_cause,
    output ready
  );
endinterface

// ----- hw/rtl/sm83_instruction_encoder_unit.sv -----
// Pipeline: request to response through three register stages.
// Throughput: one request per cycle; a stalled response holds its stage and
// the stages behind it fill before ready drops.
// Reset: rst (synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// sm83_instruction_encoder_unit
// Encodes one classified SM83 instruction into up to three code bytes or an
// error cause: range checks, then opcode build, then byte masking.
// ----------------------------------------------------------------------------
module sm83_instruction_encoder_unit (
  input logic          clk,
  input logic          rst,
  sm83enc_req_if.sink  req,
  sm83enc_rsp_if.source rsp
);

  logic adv1, adv2, adv3;
  logic v1, v2, v3;

  // stage 1 registers
  logic [5:0]  s1_kind;
  logic [1:0]  s1_n;
  logic [4:0]  s1_o1, s1_o2;
  logic [15:0] s1_v1, s1_v2;
  logic [7:0]  s1_rel1, s1_rel2, s1_spm;
  logic        s1_rel1_ok, s1_rel2_ok, s1_e8_ok, s1_spm_ok, s1_rst_ok, s1_bit_ok;

  // stage 2 registers
  sm83enc_pkg::cause_t s2_cause;
  logic [1:0] s2_cnt;
  logic [7:0] s2_b0, s2_b1, s2_b2;

  // stage 3 registers
  logic [1:0] s3_cnt;
  logic [7:0] s3_b0, s3_b1, s3_b2;
  logic [2:0] s3_cause;

  assign adv3      = !v3 || rsp.ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= req.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage 1: displacement arithmetic and range checks
  logic signed [33:0] base, rel1, rel2;
  logic [31:0]        neg2;

  always_comb begin
    base = $signed({18'b0, req.current_address}) + 34'sd2;
    rel1 = $signed({{2{req.first_value[31]}}, req.first_value}) - base;
    rel2 = $signed({{2{req.second_value[31]}}, req.second_value}) - base;
    neg2 = 32'(-req.second_value);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_kind    <= req.kind;
      s1_n       <= req.operand_count;
      s1_o1      <= req.first_operand;
      s1_o2      <= req.second_operand;
      s1_v1      <= req.first_value[15:0];
      s1_v2      <= req.second_value[15:0];
      s1_rel1    <= rel1[7:0];
      s1_rel2    <= rel2[7:0];
      s1_spm     <= neg2[7:0];
      s1_rel1_ok <= (rel1[33:7] == '0) || (rel1[33:7] == '1);
      s1_rel2_ok <= (rel2[33:7] == '0) || (rel2[33:7] == '1);
      s1_e8_ok   <= (req.second_value[31:7] == '0) || (req.second_value[31:7] == '1);
      s1_spm_ok  <= (req.second_value >= -32'sd127) && (req.second_value <= 32'sd128);
      s1_rst_ok  <= (req.first_value[31:6] == '0) && (req.first_value[2:0] == '0);
      s1_bit_ok  <= (req.first_value[31:3] == '0);
    end
  end

  // stage 2: opcode build
  sm83enc_pkg::cause_t cause;
  logic [1:0] cnt;
  logic [7:0] b0, b1, b2;
  sm83enc_pkg::sel2_t cc1, rp1, rp2, rpp;
  sm83enc_pkg::sel3_t r1, r2, rs;
  logic [2:0] y;
  logic [4:0] src;
  logic [7:0] sv;

  always_comb begin
    cause = sm83enc_pkg::ERR_NONE;
    cnt   = 2'd0;
    b0    = 8'h00;
    b1    = 8'h00;
    b2    = 8'h00;
    cc1   = sm83enc_pkg::cc_of(s1_o1);
    rp1   = sm83enc_pkg::rp_of(s1_o1);
    rp2   = sm83enc_pkg::rp_of(s1_o2);
    rpp   = sm83enc_pkg::rp2_of(s1_o1);
    r1    = sm83enc_pkg::r_of(s1_o1);
    r2    = sm83enc_pkg::r_of(s1_o2);
    y     = 3'(s1_kind - sm83enc_pkg::K_ADD);
    src   = (s1_n == 2'd2) ? s1_o2 : s1_o1;
    sv    = (s1_n == 2'd2) ? s1_v2[7:0] : s1_v1[7:0];
    rs    = sm83enc_pkg::r_of(src);
    priority if (s1_kind <= sm83enc_pkg::K_RETI) begin
      cnt = (s1_kind == sm83enc_pkg::K_STOP) ? 2'd2 : 2'd1;
      b0  = sm83enc_pkg::PLAIN_OPS[s1_kind[3:0]];
    end else if (s1_kind == sm83enc_pkg::K_RET) begin
      priority if (s1_n == 2'd0) begin
        cnt = 2'd1;
        b0  = 8'hC9;
      end else if (s1_n != 2'd1) cause = sm83enc_pkg::ERR_COUNT;
      else if (!cc1.ok) cause = sm83enc_pkg::ERR_OPERAND;
      else begin
        cnt = 2'd1;
        b0  = {3'b110, cc1.code, 3'b000};
      end
    end else if (s1_kind == sm83enc_pkg::K_RST) begin
      priority if (s1_n != 2'd1) cause = sm83enc_pkg::ERR_COUNT;
      else if (s1_o1 != sm83enc_pkg::CL_IMM) cause = sm83enc_pkg::ERR_OPERAND;
      else if (!s1_rst_ok) cause = sm83enc_pkg::ERR_RANGE;
      else begin
        cnt = 2'd1;
        b0  = {2'b11, s1_v1[5:3], 3'b111};
      end
    end else if (s1_kind == sm83enc_pkg::K_JP || s1_kind == sm83enc_pkg::K_CALL) begin
      priority if (s1_n == 2'd1) begin
        priority if (s1_kind == sm83enc_pkg::K_JP && s1_o1 == sm83enc_pkg::CL_HL) begin
          cnt = 2'd1;
          b0  = 8'hE9;
        end else if (s1_o1 == sm83enc_pkg::CL_IMM) begin
          cnt = 2'd3;
          b0  = (s1_kind == sm83enc_pkg::K_JP) ? 8'hC3 : 8'hCD;
          b1  = s1_v1[7:0];
          b2  = s1_v1[15:8];
        end else cause = sm83enc_pkg::ERR_OPERAND;
      end else if (s1_n != 2'd2) cause = sm83enc_pkg::ERR_COUNT;
      else if (!cc1.ok || s1_o2 != sm83enc_pkg::CL_IMM) cause = sm83enc_pkg::ERR_OPERAND;
      else begin
        cnt = 2'd3;
        b0  = {3'b110, cc1.code, (s1_kind == sm83enc_pkg::K_JP) ? 3'b010 : 3'b100};
        b1  = s1_v2[7:0];
        b2  = s1_v2[15:8];
      end
    end else if (s1_kind == sm83enc_pkg::K_JR) begin
      priority if (s1_n == 2'd1) begin
        priority if (s1_o1 != sm83enc_pkg::CL_IMM) cause = sm83enc_pkg::ERR_OPERAND;
        else if (!s1_rel1_ok) cause = sm83enc_pkg::ERR_RANGE;
        else begin
          cnt = 2'd2;
          b0  = 8'h18;
          b1  = s1_rel1;
        end
      end else if (s1_n == 2'd2) begin
        priority if (!cc1.ok || s1_o2 != sm83enc_pkg::CL_IMM) begin
          cause = sm83enc_pkg::ERR_OPERAND;
        end else if (!s1_rel2_ok) cause = sm83enc_pkg::ERR_RANGE;
        else begin
          cnt = 2'd2;
          b0  = {3'b001, cc1.code, 3'b000};
          b1  = s1_rel2;
        end
      end else cause = sm83enc_pkg::ERR_COUNT;
    end else if (s1_kind == sm83enc_pkg::K_PUSH || s1_kind == sm83enc_pkg::K_POP) begin
      priority if (s1_n != 2'd1) cause = sm83enc_pkg::ERR_COUNT;
      else if (!rpp.ok) cause = sm83enc_pkg::ERR_OPERAND;
      else begin
        cnt = 2'd1;
        b0  = {2'b11, rpp.code, (s1_kind == sm83enc_pkg::K_PUSH) ? 4'b0101 : 4'b0001};
      end
    end else if (s1_kind >= sm83enc_pkg::K_ADD && s1_kind <= sm83enc_pkg::K_CP) begin
      priority if (s1_kind == sm83enc_pkg::K_ADD && s1_n == 2'd2
                   && s1_o1 == sm83enc_pkg::CL_HL) begin
        if (!rp2.ok) cause = sm83enc_pkg::ERR_OPERAND;
        else begin
          cnt = 2'd1;
          b0  = {2'b00, rp2.code, 4'b1001};
        end
      end else if (s1_kind == sm83enc_pkg::K_ADD && s1_n == 2'd2
                   && s1_o1 == sm83enc_pkg::CL_SP) begin
        priority if (s1_o2 != sm83enc_pkg::CL_IMM) cause = sm83enc_pkg::ERR_OPERAND;
        else if (!s1_e8_ok) cause = sm83enc_pkg::ERR_RANGE;
        else begin
          cnt = 2'd2;
          b0  = 8'hE8;
          b1  = s1_v2[7:0];
        end
      end else if (s1_n != 2'd1 && s1_n != 2'd2) cause = sm83enc_pkg::ERR_COUNT;
      else if (s1_n == 2'd2 && s1_o1 != sm83enc_pkg::CL_A) cause = sm83enc_pkg::ERR_OPERAND;
      else if (rs.ok) begin
        cnt = 2'd1;
        b0  = {2'b10, y, rs.code};
      end else if (src == sm83enc_pkg::CL_IMM) begin
        cnt = 2'd2;
        b0  = {2'b11, y, 3'b110};
        b1  = sv;
      end else cause = sm83enc_pkg::ERR_OPERAND;
    end else if (s1_kind == sm83enc_pkg::K_INC || s1_kind == sm83enc_pkg::K_DEC) begin
      priority if (s1_n != 2'd1) cause = sm83enc_pkg::ERR_COUNT;
      else if (r1.ok) begin
        cnt = 2'd1;
        b0  = {2'b00, r1.code, (s1_kind == sm83enc_pkg::K_DEC) ? 3'b101 : 3'b100};
      end else if (rp1.ok) begin
        cnt = 2'd1;
        b0  = {2'b00, rp1.code, (s1_kind == sm83enc_pkg::K_DEC) ? 4'b1011 : 4'b0011};
      end else cause = sm83enc_pkg::ERR_OPERAND;
    end else if (s1_kind >= sm83enc_pkg::K_RLC && s1_kind <= sm83enc_pkg::K_SRL) begin
      priority if (s1_n != 2'd1) cause = sm83enc_pkg::ERR_COUNT;
      else if (!r1.ok) cause = sm83enc_pkg::ERR_OPERAND;
      else begin
        cnt = 2'd2;
        b0  = 8'hCB;
        b1  = {2'b00, 3'(s1_kind - sm83enc_pkg::K_RLC), r1.code};
      end
    end else if (s1_kind >= sm83enc_pkg::K_BIT && s1_kind <= sm83enc_pkg::K_SET) begin
      priority if (s1_n != 2'd2) cause = sm83enc_pkg::ERR_COUNT;
      else if (s1_o1 != sm83enc_pkg::CL_IMM) cause = sm83enc_pkg::ERR_OPERAND;
      else if (!s1_bit_ok) cause = sm83enc_pkg::ERR_RANGE;
      else if (!r2.ok) cause = sm83enc_pkg::ERR_OPERAND;
      else begin
        cnt = 2'd2;
        b0  = 8'hCB;
        b1  = {2'(s1_kind - sm83enc_pkg::K_SRL), s1_v1[2:0], r2.code};
      end
    end else if (s1_kind == sm83enc_pkg::K_LD) begin
      priority if (s1_n != 2'd2) cause = sm83enc_pkg::ERR_COUNT;
      else if (rp1.ok && s1_o2 == sm83enc_pkg::CL_IMM) begin
        cnt = 2'd3;
        b0  = {2'b00, rp1.code, 4'b0001};
        b1  = s1_v2[7:0];
        b2  = s1_v2[15:8];
      end else if (s1_o1 == sm83enc_pkg::CL_SP && s1_o2 == sm83enc_pkg::CL_HL) begin
        cnt = 2'd1;
        b0  = 8'hF9;
      end else if (s1_o1 == sm83enc_pkg::CL_HL && (s1_o2 == sm83enc_pkg::CL_SP_PLUS
                   || s1_o2 == sm83enc_pkg::CL_SP_MIN)) begin
        priority if (s1_o2 == sm83enc_pkg::CL_SP_MIN ? !s1_spm_ok : !s1_e8_ok) begin
          cause = sm83enc_pkg::ERR_RANGE;
        end else begin
          cnt = 2'd2;
          b0  = 8'hF8;
          b1  = (s1_o2 == sm83enc_pkg::CL_SP_MIN) ? s1_spm : s1_v2[7:0];
        end
      end else if (s1_o1 == sm83enc_pkg::CL_MEM_ADR && s1_o2 == sm83enc_pkg::CL_SP) begin
        cnt = 2'd3;
        b0  = 8'h08;
        b1  = s1_v1[7:0];
        b2  = s1_v1[15:8];
      end else if (r1.ok && r2.ok) begin
        // (hl),(hl) would be halt
        if (r1.code == 3'd6 && r2.code == 3'd6) cause = sm83enc_pkg::ERR_OPERAND;
        else begin
          cnt = 2'd1;
          b0  = {2'b01, r1.code, r2.code};
        end
      end else if (r1.ok && s1_o2 == sm83enc_pkg::CL_IMM) begin
        cnt = 2'd2;
        b0  = {2'b00, r1.code, 3'b110};
        b1  = s1_v2[7:0];
      end else begin
        cause = sm83enc_pkg::ERR_OPERAND;
        if (s1_o1 == sm83enc_pkg::CL_A) begin
          unique case (s1_o2)
            sm83enc_pkg::CL_MEM_BC:  begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'h0A; end
            sm83enc_pkg::CL_MEM_DE:  begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'h1A; end
            sm83enc_pkg::CL_MEM_HLI: begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'h2A; end
            sm83enc_pkg::CL_MEM_HLD: begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'h3A; end
            sm83enc_pkg::CL_MEM_C:   begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'hF2; end
            sm83enc_pkg::CL_MEM_ADR: begin
              cause = sm83enc_pkg::ERR_NONE;
              cnt   = 2'd3;
              b0    = 8'hFA;
              b1    = s1_v2[7:0];
              b2    = s1_v2[15:8];
            end
            default: ;
          endcase
        end
        if (s1_o2 == sm83enc_pkg::CL_A && cause != sm83enc_pkg::ERR_NONE) begin
          unique case (s1_o1)
            sm83enc_pkg::CL_MEM_BC:  begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'h02; end
            sm83enc_pkg::CL_MEM_DE:  begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'h12; end
            sm83enc_pkg::CL_MEM_HLI: begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'h22; end
            sm83enc_pkg::CL_MEM_HLD: begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'h32; end
            sm83enc_pkg::CL_MEM_C:   begin cause = sm83enc_pkg::ERR_NONE; cnt = 2'd1; b0 = 8'hE2; end
            sm83enc_pkg::CL_MEM_ADR: begin
              cause = sm83enc_pkg::ERR_NONE;
              cnt   = 2'd3;
              b0    = 8'hEA;
              b1    = s1_v1[7:0];
              b2    = s1_v1[15:8];
            end
            default: ;
          endcase
        end
      end
    end else if (s1_kind == sm83enc_pkg::K_LDH) begin
      priority if (s1_n != 2'd2) cause = sm83enc_pkg::ERR_COUNT;
      else if (s1_o1 == sm83enc_pkg::CL_MEM_ADR && s1_o2 == sm83enc_pkg::CL_A) begin
        cnt = 2'd2;
        b0  = 8'hE0;
        b1  = s1_v1[7:0];
      end else if (s1_o1 == sm83enc_pkg::CL_A && s1_o2 == sm83enc_pkg::CL_MEM_ADR) begin
        cnt = 2'd2;
        b0  = 8'hF0;
        b1  = s1_v2[7:0];
      end else cause = sm83enc_pkg::ERR_OPERAND;
    end else begin
      cause = sm83enc_pkg::ERR_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_cause <= cause;
      s2_cnt   <= cnt;
      s2_b0    <= b0;
      s2_b1    <= b1;
      s2_b2    <= b2;
    end
  end

  // stage 3: clear unused bytes, and the count and all bytes on error
  logic ok2;
  assign ok2 = (s2_cause == sm83enc_pkg::ERR_NONE);

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_cause <= 3'(s2_cause);
      s3_cnt   <= ok2 ? s2_cnt : 2'd0;
      s3_b0    <= ok2 ? s2_b0 : 8'h00;
      s3_b1    <= (ok2 && s2_cnt > 2'd1) ? s2_b1 : 8'h00;
      s3_b2    <= (ok2 && s2_cnt > 2'd2) ? s2_b2 : 8'h00;
    end
  end

  assign rsp.valid       = v3;
  assign rsp.byte_count  = s3_cnt;
  assign rsp.first_byte  = s3_b0;
  assign rsp.second_byte = s3_b1;
  assign rsp.third_byte  = s3_b2;
  assign rsp.error_cause = s3_cause;

  a_count_vs_cause: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.byte_count == 2'd0) == (rsp.error_cause != 3'd0)))
    else $error("byte count and error cause disagree");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.byte_count != 2'd3) |-> (rsp.third_byte == 8'h00))
    else $error("unused third byte not cleared");

  a_empty_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !v1 && !v2 && !v3) |=> ##2 rsp.valid)
    else $error("request lost in empty pipeline");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (v1 && v2 && v3))
    else $error("request refused with a free stage");

endmodule

// ----- tb/sm83enc_checker.sv -----
// ----------------------------------------------------------------------------
// sm83enc_checker
// Watches the request and response channels of the SM83 instruction
// encoder, works out the code bytes or error cause of every accepted
// request, and compares each accepted response with the oldest one due.
// ----------------------------------------------------------------------------
module sm83enc_checker (
  input  logic   clk,
  input  logic   rst,
  sm83enc_req_if req,
  sm83enc_rsp_if rsp,
  output int     mismatches,
  output int     pending,
  output int     compared,
  output int     rejected
);
  timeunit 1ns;
  timeprecision 1ps;

  import sm83enc_pkg::*;

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    cause_t     cause;
  } code_t;

  localparam logic [7:0] BARE_OPCODE [14] = '{
    8'h00, 8'h07, 8'h0F, 8'h17, 8'h1F, 8'h27, 8'h2F,
    8'h37, 8'h3F, 8'h76, 8'h10, 8'hF3, 8'hFB, 8'hD9
  };

  code_t expected_code_q[$];
  int    fault_count   = 0;
  int    compare_count = 0;
  int    error_count   = 0;

  function automatic code_t emit(int unsigned cnt, logic [7:0] x0, logic [7:0] x1,
                                 logic [7:0] x2);
    code_t c;
    c      = '0;
    c.n    = 2'(cnt);
    c.b0   = x0;
    if (cnt > 1) c.b1 = x1;
    if (cnt > 2) c.b2 = x2;
    c.cause = ERR_NONE;
    return c;
  endfunction

  function automatic code_t reject(cause_t e);
    code_t c;
    c       = '0;
    c.cause = e;
    return c;
  endfunction

  function automatic int cond_sel(logic [4:0] c);
    if (c >= CL_NZ && c <= CL_NC) return int'(c - CL_NZ);
    if (c == CL_C) return 3;
    return -1;
  endfunction

  function automatic int pair_sel(logic [4:0] c);
    if (c >= CL_BC && c <= CL_SP) return int'(c - CL_BC);
    return -1;
  endfunction

  function automatic int stack_pair_sel(logic [4:0] c);
    if (c >= CL_BC && c <= CL_HL) return int'(c - CL_BC);
    if (c == CL_AF) return 3;
    return -1;
  endfunction

  function automatic int reg_sel(logic [4:0] c);
    if (c <= CL_L) return int'(c);
    if (c == CL_A) return 7;
    if (c == CL_MEM_HL) return 6;
    return -1;
  endfunction

  function automatic bit in_e8(longint d);
    return d >= -128 && d <= 127;
  endfunction

  function automatic code_t encode_instr(logic [5:0] k, logic [1:0] n, logic [4:0] o1,
                                         logic [4:0] o2, logic signed [31:0] v1s,
                                         logic signed [31:0] v2s, logic [15:0] pc);
    longint     v1;
    longint     v2;
    longint     d;
    longint     sv;
    int         cc;
    int         r;
    int         r2;
    logic [7:0] op;
    logic [2:0] y;
    logic [4:0] src;
    v1 = longint'(v1s);
    v2 = longint'(v2s);
    if (k <= K_RETI) return emit(k == K_STOP ? 2 : 1, BARE_OPCODE[k], 8'h00, 8'h00);
    if (k == K_RET) begin
      if (n == 0) return emit(1, 8'hC9, 0, 0);
      if (n != 1) return reject(ERR_COUNT);
      cc = cond_sel(o1);
      if (cc < 0) return reject(ERR_OPERAND);
      return emit(1, 8'hC0 | 8'(cc << 3), 0, 0);
    end
    if (k == K_RST) begin
      if (n != 1) return reject(ERR_COUNT);
      if (o1 != CL_IMM) return reject(ERR_OPERAND);
      if (v1 < 0 || v1 > 'h38 || v1[2:0] != 3'd0) return reject(ERR_RANGE);
      return emit(1, 8'hC7 | v1[7:0], 0, 0);
    end
    if (k == K_JP || k == K_CALL) begin
      if (n == 1) begin
        if (k == K_JP && o1 == CL_HL) return emit(1, 8'hE9, 0, 0);
        if (o1 != CL_IMM) return reject(ERR_OPERAND);
        return emit(3, k == K_JP ? 8'hC3 : 8'hCD, v1[7:0], v1[15:8]);
      end
      if (n != 2) return reject(ERR_COUNT);
      cc = cond_sel(o1);
      if (cc < 0 || o2 != CL_IMM) return reject(ERR_OPERAND);
      return emit(3, (k == K_JP ? 8'hC2 : 8'hC4) | 8'(cc << 3), v2[7:0], v2[15:8]);
    end
    if (k == K_JR) begin
      if (n == 1) begin
        if (o1 != CL_IMM) return reject(ERR_OPERAND);
        d  = v1 - (longint'(pc) + 2);
        op = 8'h18;
      end else if (n == 2) begin
        cc = cond_sel(o1);
        if (cc < 0 || o2 != CL_IMM) return reject(ERR_OPERAND);
        d  = v2 - (longint'(pc) + 2);
        op = 8'h20 | 8'(cc << 3);
      end else begin
        return reject(ERR_COUNT);
      end
      if (!in_e8(d)) return reject(ERR_RANGE);
      return emit(2, op, d[7:0], 0);
    end
    if (k == K_PUSH || k == K_POP) begin
      if (n != 1) return reject(ERR_COUNT);
      r = stack_pair_sel(o1);
      if (r < 0) return reject(ERR_OPERAND);
      return emit(1, (k == K_PUSH ? 8'hC5 : 8'hC1) | 8'(r << 4), 0, 0);
    end
    if (k >= K_ADD && k <= K_CP) begin
      y = 3'(k - K_ADD);
      if (k == K_ADD && n == 2 && o1 == CL_HL) begin
        r = pair_sel(o2);
        if (r < 0) return reject(ERR_OPERAND);
        return emit(1, 8'h09 | 8'(r << 4), 0, 0);
      end
      if (k == K_ADD && n == 2 && o1 == CL_SP) begin
        if (o2 != CL_IMM) return reject(ERR_OPERAND);
        if (!in_e8(v2)) return reject(ERR_RANGE);
        return emit(2, 8'hE8, v2[7:0], 0);
      end
      if (n == 1) begin
        src = o1;
        sv  = v1;
      end else if (n == 2) begin
        if (o1 != CL_A) return reject(ERR_OPERAND);
        src = o2;
        sv  = v2;
      end else begin
        return reject(ERR_COUNT);
      end
      r = reg_sel(src);
      if (r >= 0) return emit(1, 8'h80 | {2'b00, y, 3'b000} | 8'(r), 0, 0);
      if (src == CL_IMM) return emit(2, 8'hC6 | {2'b00, y, 3'b000}, sv[7:0], 0);
      return reject(ERR_OPERAND);
    end
    if (k == K_INC || k == K_DEC) begin
      if (n != 1) return reject(ERR_COUNT);
      r = reg_sel(o1);
      if (r >= 0) return emit(1, (k == K_DEC ? 8'h05 : 8'h04) | 8'(r << 3), 0, 0);
      r = pair_sel(o1);
      if (r >= 0) return emit(1, (k == K_DEC ? 8'h0B : 8'h03) | 8'(r << 4), 0, 0);
      return reject(ERR_OPERAND);
    end
    if (k >= K_RLC && k <= K_SRL) begin
      if (n != 1) return reject(ERR_COUNT);
      r = reg_sel(o1);
      if (r < 0) return reject(ERR_OPERAND);
      return emit(2, 8'hCB, {2'b00, 3'(k - K_RLC), 3'(r)}, 0);
    end
    if (k >= K_BIT && k <= K_SET) begin
      if (n != 2) return reject(ERR_COUNT);
      if (o1 != CL_IMM) return reject(ERR_OPERAND);
      // bit number is range checked ahead of the register
      if (v1 < 0 || v1 > 7) return reject(ERR_RANGE);
      r = reg_sel(o2);
      if (r < 0) return reject(ERR_OPERAND);
      return emit(2, 8'hCB, {2'(k - K_BIT + 1), v1[2:0], 3'(r)}, 0);
    end
    if (k == K_LD) begin
      if (n != 2) return reject(ERR_COUNT);
      r = pair_sel(o1);
      if (r >= 0 && o2 == CL_IMM) return emit(3, 8'h01 | 8'(r << 4), v2[7:0], v2[15:8]);
      if (o1 == CL_SP && o2 == CL_HL) return emit(1, 8'hF9, 0, 0);
      if (o1 == CL_HL && (o2 == CL_SP_PLUS || o2 == CL_SP_MIN)) begin
        d = (o2 == CL_SP_MIN) ? -v2 : v2;
        if (!in_e8(d)) return reject(ERR_RANGE);
        return emit(2, 8'hF8, d[7:0], 0);
      end
      if (o1 == CL_MEM_ADR && o2 == CL_SP) return emit(3, 8'h08, v1[7:0], v1[15:8]);
      r  = reg_sel(o1);
      r2 = reg_sel(o2);
      if (r >= 0 && r2 >= 0) begin
        // (hl),(hl) would be the halt opcode
        if (r == 6 && r2 == 6) return reject(ERR_OPERAND);
        return emit(1, 8'h40 | 8'(r << 3) | 8'(r2), 0, 0);
      end
      if (r >= 0 && o2 == CL_IMM) return emit(2, 8'h06 | 8'(r << 3), v2[7:0], 0);
      if (o1 == CL_A) begin
        case (o2)
          CL_MEM_BC:  return emit(1, 8'h0A, 0, 0);
          CL_MEM_DE:  return emit(1, 8'h1A, 0, 0);
          CL_MEM_HLI: return emit(1, 8'h2A, 0, 0);
          CL_MEM_HLD: return emit(1, 8'h3A, 0, 0);
          CL_MEM_C:   return emit(1, 8'hF2, 0, 0);
          CL_MEM_ADR: return emit(3, 8'hFA, v2[7:0], v2[15:8]);
          default: ;
        endcase
      end
      if (o2 == CL_A) begin
        case (o1)
          CL_MEM_BC:  return emit(1, 8'h02, 0, 0);
          CL_MEM_DE:  return emit(1, 8'h12, 0, 0);
          CL_MEM_HLI: return emit(1, 8'h22, 0, 0);
          CL_MEM_HLD: return emit(1, 8'h32, 0, 0);
          CL_MEM_C:   return emit(1, 8'hE2, 0, 0);
          CL_MEM_ADR: return emit(3, 8'hEA, v1[7:0], v1[15:8]);
          default: ;
        endcase
      end
      return reject(ERR_OPERAND);
    end
    if (k == K_LDH) begin
      if (n != 2) return reject(ERR_COUNT);
      if (o1 == CL_MEM_ADR && o2 == CL_A) return emit(2, 8'hE0, v1[7:0], 0);
      if (o1 == CL_A && o2 == CL_MEM_ADR) return emit(2, 8'hF0, v2[7:0], 0);
      return reject(ERR_OPERAND);
    end
    return reject(ERR_UNKNOWN);
  endfunction

  task automatic log_fault(string what, code_t want, code_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("[%0t] %s: expected n=%0d %02h %02h %02h cause=%0d, got n=%0d %02h %02h %02h cause=%0d",
               $time, what, want.n, want.b0, want.b1, want.b2, want.cause,
               got.n, got.b0, got.b1, got.b2, got.cause);
  endtask

  always @(posedge clk) begin
    code_t got;
    code_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got.n     = rsp.byte_count;
        got.b0    = rsp.first_byte;
        got.b1    = rsp.second_byte;
        got.b2    = rsp.third_byte;
        got.cause = cause_t'(rsp.error_cause);
        compare_count++;
        if (got.cause != ERR_NONE) error_count++;
        if (expected_code_q.size() == 0) begin
          log_fault("response with no request outstanding", '0, got);
        end else begin
          want = expected_code_q.pop_front();
          if (got.n != want.n || got.b0 != want.b0 || got.b1 != want.b1 ||
              got.b2 != want.b2 || got.cause != want.cause)
            log_fault("response mismatch", want, got);
        end
      end
      if (req.valid && req.ready)
        expected_code_q.push_back(encode_instr(req.kind, req.operand_count, req.first_operand,
                                               req.second_operand, req.first_value,
                                               req.second_value, req.current_address));
    end
    mismatches <= fault_count;
    pending    <= expected_code_q.size();
    compared   <= compare_count;
    rejected   <= error_count;
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the SM83 instruction encoder bench: a directed set of edge cases,
// then shaped random instructions with idling on both channels; checking
// is left to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sm83enc_pkg::*;

  localparam int         RANDOM_ITEMS    = 1425;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam logic [5:0] K_NOP           = 6'd0;
  localparam logic [5:0] K_FIRST_UNKNOWN = K_LDH + 6'd1;
  localparam logic [5:0] K_LAST          = 6'h3F;
  localparam logic [4:0] CL_B            = 5'd0;
  localparam logic [4:0] CL_MEM_BAD      = 5'd23;

  typedef struct packed {
    logic [5:0]         kind;
    logic [1:0]         operand_count;
    logic [4:0]         first_operand;
    logic [4:0]         second_operand;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic [15:0]        current_address;
  } instr_t;

  logic clk;
  logic rst;
  bit   no_idle;
  int   sent   = 0;
  int   cycles = 0;
  int   directed;
  int   mismatches;
  int   pending;
  int   compared;
  int   rejected;

  sm83enc_req_if req ();
  sm83enc_rsp_if rsp ();

  sm83_instruction_encoder_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  sm83enc_checker encoder_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared),
    .rejected   (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial rsp.ready = 1'b0;

  always @(posedge clk) rsp.ready <= no_idle || ($urandom_range(0, 99) >= 8);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic instr_t mk(logic [5:0] k, int n, logic [4:0] o1, logic [4:0] o2,
                                int v1, int v2, int pc);
    instr_t x;
    x.kind            = k;
    x.operand_count   = 2'(n);
    x.first_operand   = o1;
    x.second_operand  = o2;
    x.first_value     = v1;
    x.second_value    = v2;
    x.current_address = 16'(pc);
    return x;
  endfunction

  function automatic logic [4:0] pick_r8();
    if ($urandom_range(0, 7) == 0) return CL_MEM_HL;
    return 5'($urandom_range(CL_B, CL_A));
  endfunction

  function automatic logic [4:0] pick_cond();
    if ($urandom_range(0, 3) == 0) return CL_C;
    return 5'($urandom_range(CL_NZ, CL_NC));
  endfunction

  function automatic logic [4:0] pick_src();
    if ($urandom_range(0, 7) == 0) return CL_IMM;
    return pick_r8();
  endfunction

  function automatic logic [4:0] pick_mem();
    return 5'($urandom_range(CL_MEM_BC, CL_MEM_BAD));
  endfunction

  function automatic int random_value();
    case ($urandom_range(0, 5))
      0: return int'($urandom);
      1: return int'($urandom_range(0, 600)) - 300;
      2: return int'($urandom_range(0, 'hFFFF));
      3: return int'($urandom_range(0, 9)) * 8;
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 8));
    endcase
  endfunction

  function automatic instr_t make_instr();
    instr_t x;
    int     disp;
    x.kind = ($urandom_range(0, 99) < 8) ? 6'($urandom_range(K_FIRST_UNKNOWN, K_LAST))
                                         : 6'($urandom_range(K_NOP, K_LDH));
    x.operand_count   = 2'($urandom);
    x.first_operand   = 5'($urandom);
    x.second_operand  = 5'($urandom);
    x.first_value     = random_value();
    x.second_value    = random_value();
    x.current_address = 16'($urandom);
    if ($urandom_range(0, 19) == 0)
      x.current_address = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    // a fifth of the traffic stays as raw noise
    if ($urandom_range(0, 99) < 20) return x;
    disp = int'($urandom_range(0, 280)) - 140;
    if (x.kind == K_RET) begin
      x.operand_count = 2'($urandom_range(0, 1));
      x.first_operand = pick_cond();
    end else if (x.kind == K_RST) begin
      x.operand_count = 2'd1;
      x.first_operand = CL_IMM;
    end else if (x.kind == K_JP || x.kind == K_CALL) begin
      x.operand_count  = 2'($urandom_range(1, 2));
      x.first_operand  = (x.operand_count == 2'd2) ? pick_cond()
                         : ($urandom_range(0, 3) == 0 ? CL_HL : CL_IMM);
      x.second_operand = CL_IMM;
    end else if (x.kind == K_JR) begin
      x.operand_count  = 2'($urandom_range(1, 2));
      x.first_operand  = (x.operand_count == 2'd2) ? pick_cond() : CL_IMM;
      x.second_operand = CL_IMM;
      x.first_value    = int'(x.current_address) + 2 + disp;
      x.second_value   = int'(x.current_address) + 2 + disp;
    end else if (x.kind == K_PUSH || x.kind == K_POP) begin
      x.operand_count = 2'd1;
      x.first_operand = 5'($urandom_range(CL_BC, CL_AF));
    end else if (x.kind >= K_ADD && x.kind <= K_CP) begin
      x.operand_count  = 2'($urandom_range(1, 2));
      x.first_operand  = pick_src();
      x.second_operand = pick_src();
      if (x.operand_count == 2'd2) begin
        x.first_operand = ($urandom_range(0, 9) == 0) ? pick_r8() : CL_A;
        if (x.kind == K_ADD && $urandom_range(0, 2) == 0) begin
          x.first_operand  = $urandom_range(0, 1) ? CL_HL : CL_SP;
          x.second_operand = (x.first_operand == CL_HL) ? 5'($urandom_range(CL_BC, CL_AF))
                                                        : CL_IMM;
          x.second_value   = disp;
        end
      end
    end else if (x.kind == K_INC || x.kind == K_DEC) begin
      x.operand_count = 2'd1;
      x.first_operand = ($urandom_range(0, 7) == 0) ? CL_MEM_HL
                                                    : 5'($urandom_range(CL_B, CL_AF));
    end else if (x.kind >= K_RLC && x.kind <= K_SRL) begin
      x.operand_count = 2'd1;
      x.first_operand = pick_r8();
    end else if (x.kind >= K_BIT && x.kind <= K_SET) begin
      x.operand_count  = 2'd2;
      x.first_operand  = CL_IMM;
      x.first_value    = int'($urandom_range(0, 8));
      x.second_operand = pick_r8();
    end else if (x.kind == K_LD) begin
      x.operand_count = 2'd2;
      case ($urandom_range(0, 7))
        0: begin
          x.first_operand  = 5'($urandom_range(CL_BC, CL_SP));
          x.second_operand = CL_IMM;
        end
        1: begin
          x.first_operand  = CL_SP;
          x.second_operand = CL_HL;
        end
        2: begin
          x.first_operand  = CL_HL;
          x.second_operand = $urandom_range(0, 1) ? CL_SP_PLUS : CL_SP_MIN;
          x.second_value   = disp;
        end
        3: begin
          x.first_operand  = CL_MEM_ADR;
          x.second_operand = CL_SP;
        end
        4: begin
          x.first_operand  = pick_r8();
          x.second_operand = pick_r8();
        end
        5: begin
          x.first_operand  = pick_r8();
          x.second_operand = CL_IMM;
        end
        6: begin
          x.first_operand  = CL_A;
          x.second_operand = pick_mem();
        end
        default: begin
          x.first_operand  = pick_mem();
          x.second_operand = CL_A;
        end
      endcase
    end else if (x.kind == K_LDH) begin
      x.operand_count = 2'd2;
      if ($urandom_range(0, 1)) begin
        x.first_operand  = ($urandom_range(0, 3) == 0) ? pick_mem() : CL_MEM_ADR;
        x.second_operand = CL_A;
      end else begin
        x.first_operand  = CL_A;
        x.second_operand = ($urandom_range(0, 3) == 0) ? pick_mem() : CL_MEM_ADR;
      end
    end
    return x;
  endfunction

  task automatic send_request(instr_t x);
    if (!no_idle && $urandom_range(0, 99) < 8) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid           <= 1'b1;
    req.kind            <= x.kind;
    req.operand_count   <= x.operand_count;
    req.first_operand   <= x.first_operand;
    req.second_operand  <= x.second_operand;
    req.first_value     <= x.first_value;
    req.second_value    <= x.second_value;
    req.current_address <= x.current_address;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    instr_t plan[$];
    rst                 <= 1'b1;
    req.valid           <= 1'b0;
    req.kind            <= '0;
    req.operand_count   <= '0;
    req.first_operand   <= '0;
    req.second_operand  <= '0;
    req.first_value     <= '0;
    req.second_value    <= '0;
    req.current_address <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(mk(K_NOP, 0, CL_B, CL_B, 0, 0, 0));
    plan.push_back(mk(K_STOP, 3, CL_IMM, CL_HL, -1, -1, 'hFFFF));
    plan.push_back(mk(K_RETI, 1, CL_A, CL_A, 0, 0, 0));
    plan.push_back(mk(K_LAST, 2, CL_A, CL_B, 0, 0, 0));
    plan.push_back(mk(K_RET, 0, CL_B, CL_B, 0, 0, 0));
    plan.push_back(mk(K_RET, 1, CL_C, CL_B, 0, 0, 0));
    plan.push_back(mk(K_RET, 2, CL_NZ, CL_IMM, 0, 0, 0));
    plan.push_back(mk(K_RST, 1, CL_IMM, CL_B, 'h38, 0, 0));
    plan.push_back(mk(K_RST, 1, CL_IMM, CL_B, 'h3C, 0, 0));
    plan.push_back(mk(K_RST, 1, CL_IMM, CL_B, -8, 0, 0));
    plan.push_back(mk(K_JP, 1, CL_HL, CL_B, 0, 0, 0));
    plan.push_back(mk(K_JP, 2, CL_NC, CL_IMM, 0, 'hFFFF, 0));
    plan.push_back(mk(K_JR, 1, CL_IMM, CL_B, 'h10080, 0, 'hFFFF));
    plan.push_back(mk(K_JR, 2, CL_C, CL_IMM, 0, 'h0F82, 'h1000));
    plan.push_back(mk(K_JR, 1, CL_IMM, CL_B, 'h1082, 0, 'h1000));
    plan.push_back(mk(K_JR, 1, CL_IMM, CL_B, 32'h8000_0000, 0, 0));
    plan.push_back(mk(K_CALL, 3, CL_IMM, CL_IMM, 0, 0, 0));
    plan.push_back(mk(K_ADD, 2, CL_HL, CL_SP, 0, 0, 0));
    plan.push_back(mk(K_ADD, 2, CL_SP, CL_IMM, 0, -128, 0));
    plan.push_back(mk(K_ADD, 2, CL_SP, CL_IMM, 0, 128, 0));
    plan.push_back(mk(K_ADD, 2, CL_B, CL_C, 0, 0, 0));
    plan.push_back(mk(K_CP, 2, CL_A, CL_IMM, 0, 32'h7FFF_FFFF, 0));
    plan.push_back(mk(K_LD, 2, CL_MEM_HL, CL_MEM_HL, 0, 0, 0));
    plan.push_back(mk(K_LD, 2, CL_HL, CL_SP_MIN, 0, 128, 0));
    plan.push_back(mk(K_LD, 2, CL_HL, CL_SP_MIN, 0, -128, 0));
    plan.push_back(mk(K_LD, 2, CL_MEM_ADR, CL_SP, 'hABCD1234, 0, 0));
    plan.push_back(mk(K_LDH, 2, CL_A, CL_MEM_C, 0, 0, 0));
    plan.push_back(mk(K_LDH, 2, CL_MEM_ADR, CL_A, 'hFF10, 0, 0));
    plan.push_back(mk(K_BIT, 2, CL_IMM, CL_BC, 8, 0, 0));
    plan.push_back(mk(K_SET, 2, CL_IMM, CL_MEM_HL, 7, 0, 0));
    directed = plan.size();
    foreach (plan[i]) send_request(plan[i]);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long stretch with both channels flat out
      no_idle <= (i >= 500 && i < 800);
      if (i == 1000) drain();
      send_request(make_instr());
    end
    drain();
    repeat (8) @(posedge clk);

    $display("%0d instructions sent (%0d directed edge cases, the rest shaped random forms and noise)",
             sent, directed);
    $display("%0d responses compared, %0d of them carrying an error cause", compared, rejected);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
